@@ src/csl_pkg.sv @@
// Package for the C subset lexer: token record, kind codes, character codes
// and the keyword table. It depends on nothing and is used by every module.
package csl_pkg;

  localparam int KW_CHARS = 8;
  localparam int KW_IDX_W = $clog2(KW_CHARS);
  localparam int KW_W     = KW_CHARS * 8;
  localparam int NUM_KW   = 9;
  localparam int Q_DEPTH  = 4;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [19:0] POS_MAX = 20'hFFFFF;
  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  localparam logic [5:0] K_EOF    = 6'd0;
  localparam logic [5:0] K_LPAR   = 6'd1;
  localparam logic [5:0] K_RPAR   = 6'd2;
  localparam logic [5:0] K_LBRACE = 6'd3;
  localparam logic [5:0] K_RBRACE = 6'd4;
  localparam logic [5:0] K_LBRACK = 6'd5;
  localparam logic [5:0] K_RBRACK = 6'd6;
  localparam logic [5:0] K_SEMI   = 6'd7;
  localparam logic [5:0] K_COMMA  = 6'd8;
  localparam logic [5:0] K_PLUS   = 6'd9;
  localparam logic [5:0] K_MINUS  = 6'd10;
  localparam logic [5:0] K_STAR   = 6'd11;
  localparam logic [5:0] K_SLASH  = 6'd12;
  localparam logic [5:0] K_AMP    = 6'd13;
  localparam logic [5:0] K_ANDAND = 6'd14;
  localparam logic [5:0] K_ASSIGN = 6'd15;
  localparam logic [5:0] K_EQ     = 6'd16;
  localparam logic [5:0] K_BANG   = 6'd17;
  localparam logic [5:0] K_NE     = 6'd18;
  localparam logic [5:0] K_OROR   = 6'd19;
  localparam logic [5:0] K_LT     = 6'd20;
  localparam logic [5:0] K_LE     = 6'd21;
  localparam logic [5:0] K_GT     = 6'd22;
  localparam logic [5:0] K_GE     = 6'd23;
  localparam logic [5:0] K_NUMBER = 6'd24;
  localparam logic [5:0] K_IDENT  = 6'd25;
  localparam logic [5:0] K_KW0    = 6'd26;
  localparam logic [5:0] K_ERROR  = 6'd35;

  localparam logic [7:0] C_TAB   = 8'h09;
  localparam logic [7:0] C_LF    = 8'h0A;
  localparam logic [7:0] C_CR    = 8'h0D;
  localparam logic [7:0] C_SPACE = 8'h20;
  localparam logic [7:0] C_BANG  = 8'h21;
  localparam logic [7:0] C_AMP   = 8'h26;
  localparam logic [7:0] C_LPAR  = 8'h28;
  localparam logic [7:0] C_RPAR  = 8'h29;
  localparam logic [7:0] C_STAR  = 8'h2A;
  localparam logic [7:0] C_PLUS  = 8'h2B;
  localparam logic [7:0] C_COMMA = 8'h2C;
  localparam logic [7:0] C_MINUS = 8'h2D;
  localparam logic [7:0] C_SLASH = 8'h2F;
  localparam logic [7:0] C_ZERO  = 8'h30;
  localparam logic [7:0] C_NINE  = 8'h39;
  localparam logic [7:0] C_SEMI  = 8'h3B;
  localparam logic [7:0] C_LT    = 8'h3C;
  localparam logic [7:0] C_EQ    = 8'h3D;
  localparam logic [7:0] C_GT    = 8'h3E;
  localparam logic [7:0] C_LBRK  = 8'h5B;
  localparam logic [7:0] C_RBRK  = 8'h5D;
  localparam logic [7:0] C_UNDER = 8'h5F;
  localparam logic [7:0] C_LBRC  = 8'h7B;
  localparam logic [7:0] C_PIPE  = 8'h7C;
  localparam logic [7:0] C_RBRC  = 8'h7D;

  typedef enum logic [4:0] {
    M_IDLE    = 5'b00001,
    M_OP      = 5'b00010,
    M_NUM     = 5'b00100,
    M_IDENT   = 5'b01000,
    M_COMMENT = 5'b10000
  } mode_e;

  typedef struct packed {
    logic        last;
    logic [15:0] len;
    logic [31:0] off;
    logic [19:0] col;
    logic [19:0] line;
    logic [30:0] value;
    logic [5:0]  kind;
  } token_t;

  typedef struct packed {
    logic [1:0] cnt;
    token_t     tok1;
    token_t     tok0;
  } push_t;

  localparam logic [KW_W-1:0] KW_TEXT [NUM_KW] = '{
    KW_W'(64'h0000_0000_0074_6e69),
    KW_W'(64'h0000_0000_6469_6f76),
    KW_W'(64'h0000_6e72_7574_6572),
    KW_W'(64'h0000_0000_0000_6669),
    KW_W'(64'h0000_0000_6573_6c65),
    KW_W'(64'h0000_0065_6c69_6877),
    KW_W'(64'h0000_0000_0072_6f66),
    KW_W'(64'h0000_006b_6165_7262),
    KW_W'(64'h6575_6e69_746e_6f63)
  };
  localparam logic [15:0] KW_LEN [NUM_KW] = '{
    16'd3, 16'd4, 16'd6, 16'd2, 16'd4, 16'd5, 16'd3, 16'd5, 16'd8
  };

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      C_LPAR:  k = K_LPAR;
      C_RPAR:  k = K_RPAR;
      C_LBRC:  k = K_LBRACE;
      C_RBRC:  k = K_RBRACE;
      C_LBRK:  k = K_LBRACK;
      C_RBRK:  k = K_RBRACK;
      C_SEMI:  k = K_SEMI;
      C_COMMA: k = K_COMMA;
      C_PLUS:  k = K_PLUS;
      C_MINUS: k = K_MINUS;
      C_STAR:  k = K_STAR;
      C_SLASH: k = K_SLASH;
      C_AMP:   k = K_AMP;
      C_EQ:    k = K_ASSIGN;
      C_BANG:  k = K_BANG;
      C_LT:    k = K_LT;
      C_GT:    k = K_GT;
      default: k = K_EOF;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
    logic [5:0] k;
    k = K_EOF;
    if (p == C_AMP && c == C_AMP) k = K_ANDAND;
    if (p == C_EQ && c == C_EQ) k = K_EQ;
    if (p == C_BANG && c == C_EQ) k = K_NE;
    if (p == C_PIPE && c == C_PIPE) k = K_OROR;
    if (p == C_LT && c == C_EQ) k = K_LE;
    if (p == C_GT && c == C_EQ) k = K_GE;
    return k;
  endfunction

endpackage

@@ src/csl_front.sv @@
// Scanner front end of the C subset lexer: classifies each byte and forms up
// to two tokens per byte. Depends on csl_pkg.
module csl_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  logic [7:0]      byte_i,
  input  logic            end_i,
  output csl_pkg::push_t  push_o
);

  csl_pkg::mode_e mode_q, mode_d;
  logic [7:0]  pend_q, pend_d;
  logic [31:0] acc_q, acc_d;
  logic [csl_pkg::KW_CHARS-1:0][7:0] kbuf_q, kbuf_d;
  logic [15:0] len_q, len_d;
  logic [31:0] coff_q, coff_d;
  logic [19:0] cline_q, cline_d, ccol_q, ccol_d;
  logic [19:0] sline_q, sline_d, scol_q, scol_d;
  logic [31:0] soff_q, soff_d;
  logic        halt_q, halt_d;

  logic [31:0] step_off;
  logic [19:0] step_line, step_col;
  logic        is_dig, is_alp;
  logic [34:0] acc_x;
  logic [5:0]  wkind;
  logic [15:0] len_inc;

  always_comb begin
    step_off  = coff_q + 32'd1;
    step_line = cline_q;
    step_col  = ccol_q;
    if (byte_i == csl_pkg::C_LF) begin
      if (cline_q < csl_pkg::POS_MAX) step_line = cline_q + 20'd1;
      step_col = 20'd1;
    end else if (ccol_q < csl_pkg::POS_MAX) begin
      step_col = ccol_q + 20'd1;
    end
    is_dig = (byte_i >= csl_pkg::C_ZERO) && (byte_i <= csl_pkg::C_NINE);
    is_alp = (byte_i >= 8'h61 && byte_i <= 8'h7A) || (byte_i >= 8'h41 && byte_i <= 8'h5A) ||
             (byte_i == csl_pkg::C_UNDER);
    acc_x = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + 35'(byte_i - csl_pkg::C_ZERO);
    len_inc = (len_q < csl_pkg::LEN_MAX) ? len_q + 16'd1 : len_q;
    wkind = csl_pkg::K_IDENT;
    if (len_q <= 16'(csl_pkg::KW_CHARS)) begin
      for (int i = 0; i < csl_pkg::NUM_KW; i++) begin
        if (csl_pkg::KW_LEN[i] == len_q && csl_pkg::KW_TEXT[i] == kbuf_q) begin
          wkind = csl_pkg::K_KW0 + 6'(i);
        end
      end
    end
  end

  always_comb begin
    csl_pkg::token_t t;
    logic do_flush, flush_ok, do_idle, emit, eof;
    mode_d = mode_q; pend_d = pend_q; acc_d = acc_q; kbuf_d = kbuf_q; len_d = len_q;
    coff_d = coff_q; cline_d = cline_q; ccol_d = ccol_q;
    sline_d = sline_q; scol_d = scol_q; soff_d = soff_q; halt_d = halt_q;
    push_o = '0;
    t = '0;
    do_flush = 1'b0; flush_ok = 1'b1; do_idle = 1'b0; emit = 1'b0; eof = 1'b0;

    if (fire_i && !halt_q) begin
      if (end_i) begin
        do_flush = 1'b1;
        eof = 1'b1;
      end else if (mode_q == csl_pkg::M_COMMENT) begin
        if (byte_i == csl_pkg::C_LF) mode_d = csl_pkg::M_IDLE;
        coff_d = step_off; cline_d = step_line; ccol_d = step_col;
      end else if (mode_q == csl_pkg::M_OP) begin
        if (pend_q == csl_pkg::C_SLASH && byte_i == csl_pkg::C_SLASH) begin
          mode_d = csl_pkg::M_COMMENT;
          coff_d = step_off; cline_d = step_line; ccol_d = step_col;
        end else if (csl_pkg::pair_kind(pend_q, byte_i) != csl_pkg::K_EOF) begin
          push_o.tok0 = '{last: 1'b0, len: 16'd2, off: soff_q, col: scol_q, line: sline_q,
                          value: '0, kind: csl_pkg::pair_kind(pend_q, byte_i)};
          push_o.cnt = 2'd1;
          mode_d = csl_pkg::M_IDLE;
          coff_d = step_off; cline_d = step_line; ccol_d = step_col;
        end else begin
          do_flush = 1'b1; do_idle = 1'b1;
        end
      end else if (mode_q == csl_pkg::M_NUM && is_dig) begin
        if (!acc_q[31]) acc_d = (acc_x > 35'h7FFF_FFFF) ? 32'h8000_0000 : acc_x[31:0];
        len_d = len_inc;
        coff_d = step_off; cline_d = step_line; ccol_d = step_col;
      end else if (mode_q == csl_pkg::M_IDENT && (is_alp || is_dig)) begin
        if (len_q < 16'(csl_pkg::KW_CHARS)) kbuf_d[len_q[csl_pkg::KW_IDX_W-1:0]] = byte_i;
        len_d = len_inc;
        coff_d = step_off; cline_d = step_line; ccol_d = step_col;
      end else begin
        do_flush = 1'b1; do_idle = 1'b1;
      end

      if (do_flush) begin
        mode_d = csl_pkg::M_IDLE;
        emit = 1'b1;
        t = '{last: 1'b0, len: len_q, off: soff_q, col: scol_q, line: sline_q,
              value: '0, kind: csl_pkg::K_EOF};
        case (mode_q)
          csl_pkg::M_OP: begin
            t.len = 16'd1;
            t.kind = csl_pkg::single_kind(pend_q);
            if (pend_q == csl_pkg::C_PIPE) flush_ok = 1'b0;
          end
          csl_pkg::M_NUM: begin
            t.kind = csl_pkg::K_NUMBER;
            t.value = acc_q[30:0];
            if (acc_q[31]) flush_ok = 1'b0;
          end
          csl_pkg::M_IDENT: t.kind = wkind;
          default: emit = 1'b0;
        endcase
        if (!flush_ok) begin
          t = '{last: 1'b0, len: '0, off: coff_q, col: ccol_q, line: cline_q,
                value: '0, kind: csl_pkg::K_ERROR};
          halt_d = 1'b1;
        end
        if (emit || !flush_ok) begin
          push_o.tok0 = t;
          push_o.cnt = 2'd1;
        end
      end

      if (flush_ok && eof) begin
        halt_d = 1'b1;
        t = '{last: 1'b0, len: '0, off: coff_q, col: ccol_q, line: cline_q,
              value: '0, kind: csl_pkg::K_EOF};
        if (push_o.cnt == 2'd0) push_o.tok0 = t;
        else push_o.tok1 = t;
        push_o.cnt = push_o.cnt + 2'd1;
      end

      if (flush_ok && do_idle) begin
        coff_d = step_off; cline_d = step_line; ccol_d = step_col;
        if (!(byte_i inside {csl_pkg::C_SPACE, csl_pkg::C_TAB, csl_pkg::C_CR,
                             csl_pkg::C_LF})) begin
          sline_d = cline_q; scol_d = ccol_q; soff_d = coff_q;
          emit = 1'b0;
          t = '{last: 1'b0, len: 16'd1, off: coff_q, col: ccol_q, line: cline_q,
                value: '0, kind: csl_pkg::single_kind(byte_i)};
          if (byte_i inside {csl_pkg::C_AMP, csl_pkg::C_EQ, csl_pkg::C_BANG, csl_pkg::C_PIPE,
                             csl_pkg::C_LT, csl_pkg::C_GT, csl_pkg::C_SLASH}) begin
            mode_d = csl_pkg::M_OP;
            pend_d = byte_i;
          end else if (t.kind != csl_pkg::K_EOF) begin
            emit = 1'b1;
          end else if (is_dig) begin
            mode_d = csl_pkg::M_NUM;
            acc_d = {24'd0, byte_i - csl_pkg::C_ZERO};
            len_d = 16'd1;
          end else if (is_alp) begin
            mode_d = csl_pkg::M_IDENT;
            kbuf_d = '0;
            kbuf_d[0] = byte_i;
            len_d = 16'd1;
          end else begin
            emit = 1'b1;
            halt_d = 1'b1;
            t = '{last: 1'b0, len: '0, off: step_off, col: step_col, line: step_line,
                  value: '0, kind: csl_pkg::K_ERROR};
          end
          if (emit) begin
            if (push_o.cnt == 2'd0) push_o.tok0 = t;
            else push_o.tok1 = t;
            push_o.cnt = push_o.cnt + 2'd1;
          end
        end
      end

      if (push_o.cnt == 2'd1) push_o.tok0.last = 1'b1;
      if (push_o.cnt == 2'd2) push_o.tok1.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= csl_pkg::M_IDLE;
      pend_q <= '0;
      acc_q <= '0;
      kbuf_q <= '0;
      len_q <= '0;
      coff_q <= '0;
      cline_q <= 20'd1;
      ccol_q <= 20'd1;
      sline_q <= 20'd1;
      scol_q <= 20'd1;
      soff_q <= '0;
      halt_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      pend_q <= pend_d;
      acc_q <= acc_d;
      kbuf_q <= kbuf_d;
      len_q <= len_d;
      coff_q <= coff_d;
      cline_q <= cline_d;
      ccol_q <= ccol_d;
      sline_q <= sline_d;
      scol_q <= scol_d;
      soff_q <= soff_d;
      halt_q <= halt_d;
    end
  end

endmodule

@@ src/csl_queue.sv @@
// Token queue and output side of the C subset lexer: takes up to two tokens a
// cycle from the scanner and presents one a cycle on ready_i. Depends on csl_pkg.
module csl_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  csl_pkg::push_t  push_i,
  output logic            room_o,
  output logic            valid_o,
  input  logic            ready_i,
  output csl_pkg::token_t tok_o
);

  csl_pkg::token_t mem_q [csl_pkg::Q_DEPTH];
  logic [csl_pkg::Q_PTR_W-1:0] wp_q, rp_q;
  logic [csl_pkg::Q_CNT_W-1:0] cnt_q, cnt_d;
  logic pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = cnt_q != '0;
  assign room_o  = cnt_q <= csl_pkg::Q_CNT_W'(csl_pkg::Q_DEPTH - 2);
  assign tok_o   = mem_q[rp_q];
  assign cnt_d   = cnt_q + csl_pkg::Q_CNT_W'(push_i.cnt) - csl_pkg::Q_CNT_W'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wp_q] <= push_i.tok0;
    if (push_i.cnt == 2'd2) mem_q[wp_q + csl_pkg::Q_PTR_W'(1)] <= push_i.tok1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      wp_q <= wp_q + csl_pkg::Q_PTR_W'(push_i.cnt);
      rp_q <= rp_q + csl_pkg::Q_PTR_W'(pop);
      cnt_q <= cnt_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= csl_pkg::Q_CNT_W'(csl_pkg::Q_DEPTH)) else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !room_o |-> push_i.cnt == 2'd0) else $error("push into full queue");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wp_q - rp_q) == cnt_q[csl_pkg::Q_PTR_W-1:0]) else $error("queue pointers disagree");
`endif

endmodule

@@ src/c_subset_lexer_unit.sv @@
// C subset lexer: bytes in on tdata with end of input on tlast, tokens out
// with position, length and number value. Depends on csl_pkg, csl_front, csl_queue.
//
// The lexer takes one source byte per cycle while s_axis_tready is high; the
// scanner's state is registered, and it writes up to two tokens into a four-entry
// queue; s_axis_tready drops only while the queue has fewer than two free entries.
// Tokens leave at one per cycle while m_axis_tready is high, so a byte that ends
// one token and forms another gives two tokens to send. After an error or EOF
// token the lexer accepts bytes but produces nothing until reset.
module c_subset_lexer_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // input_byte[7:0]
  input  logic         s_axis_tlast,   // end_of_input
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // token_kind[5:0], number_value[36:6], token_line[56:37], token_column[76:57],
  // token_offset[108:77], token_length[124:109], zero[127:125]
  output logic [127:0] m_axis_tdata,
  output logic         m_axis_tlast    // last_of_run
);

  csl_pkg::push_t  push;
  csl_pkg::token_t tok;
  logic room;

  assign s_axis_tready = room;

  csl_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s_axis_tvalid && room),
    .byte_i (s_axis_tdata),
    .end_i  (s_axis_tlast),
    .push_o (push)
  );

  csl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .tok_o   (tok)
  );

  assign m_axis_tdata = {3'b000, tok.len, tok.off, tok.col, tok.line, tok.value, tok.kind};
  assign m_axis_tlast = tok.last;

endmodule
